FILE: rtl/lccs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and the slot entry layout of the collision scan core.
package lccs_pkg;

  localparam int MAX_COLLIDERS = 16;
  localparam int IDX_W         = $clog2(MAX_COLLIDERS);
  localparam int SLOT_W        = 4;
  localparam int CMP_W         = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
  localparam int CNT_W         = IDX_W + 1;

  localparam int COORD_W = 16;
  localparam int RAD_W   = 15;
  localparam int LAYER_W = 32;
  localparam int MAG_W   = 16;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int ACC_W   = SQ_W + 1;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 8;

  localparam logic CMD_LOAD      = 1'b0;
  localparam logic CMD_SCAN      = 1'b1;
  localparam logic EVT_COLLISION = 1'b0;
  localparam logic EVT_ROW_DONE  = 1'b1;

  typedef struct packed {
    logic [LAYER_W-1:0]        collide_mask;
    logic [LAYER_W-1:0]        member_layer;
    logic [RAD_W-1:0]          radius;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_x;
  } lccs_entry_t;

  localparam int ENTRY_W = $bits(lccs_entry_t);

endpackage

FILE: rtl/lccs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module lccs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

FILE: rtl/lccs_square_unit.sv
`timescale 1ns / 1ps
// Shared squaring unit: one registered 16 x 16 product per cycle.
module lccs_square_unit
  import lccs_pkg::*;
(
  input  logic             clk,
  input  logic [MAG_W-1:0] op,
  output logic [SQ_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= SQ_W'(op) * SQ_W'(op);
  end

endmodule

FILE: rtl/layered_circle_collision_scan_core.sv
`timescale 1ns / 1ps
// Top level: slot table, scan sequencer around the shared squaring unit, output register.
//
//   channel | dir | tdata / tuser / tlast
//   in_     | in  | tdata: slot, entry_valid, pos_x, pos_y, radius, shape_kind,
//           |     |        member_layer, collide_mask, has_handler; tuser: cmd
//   out_    | out | tdata: self_slot, other_slot; tuser: event_kind; tlast: last
//
// A load writes one slot and its flags. A scan skips empty later slots, drops later pairs
// rejected by layer or shape, puts every other pair through the squaring unit (dx^2, dy^2,
// (ri+rj)^2 in turn) and, when that pair overlaps, emits an item for each side with a handler.
// Reset clears the slot flags, the sequencer state and the output valid; table contents stay undefined until loaded.
// A stalled output holds the sequencer; a new item is taken only while idle.
module layered_circle_collision_scan_core
  import lccs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // slot[3:0], entry_valid[4], pos_x[20:5], pos_y[36:21], radius[51:37],
  // shape_kind[52], member_layer[84:53], collide_mask[116:85], has_handler[117]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,   // cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // self_slot[3:0], other_slot[7:4]
  output logic                  out_tuser,  // event_kind
  output logic                  out_tlast   // last
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ROW, ST_SEEK, ST_FETCH, ST_SQ_X, ST_SQ_Y, ST_SQ_R, ST_CMP,
    ST_EMIT_I, ST_EMIT_J, ST_DONE
  } state_t;

  state_t state_r;

  logic [SLOT_W-1:0]  in_slot;
  logic               in_entry_valid;
  logic               in_shape_kind;
  logic               in_has_handler;
  lccs_entry_t        in_entry;
  logic               in_acc;
  logic               in_range;
  logic [IDX_W-1:0]   in_idx;

  logic [MAX_COLLIDERS-1:0] valid_r;
  logic [MAX_COLLIDERS-1:0] other_shape_r;
  logic [MAX_COLLIDERS-1:0] handler_r;

  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;
  lccs_entry_t        rd_entry;

  logic [SLOT_W-1:0]  slot_r;
  logic [IDX_W-1:0]   row_idx_r;
  lccs_entry_t        row_r;
  logic               row_other_r;
  logic               row_handler_r;
  logic [CNT_W-1:0]   j_r;
  logic [IDX_W-1:0]   j_idx;

  logic [MAG_W-1:0]   dx_r;
  logic [MAG_W-1:0]   dy_r;
  logic [MAG_W-1:0]   rs_r;
  logic               self_hit_r;
  logic               other_hit_r;
  logic               j_handler_r;
  logic [ACC_W-1:0]   acc_r;

  logic [MAG_W-1:0]   sq_op;
  logic [SQ_W-1:0]    sq_prod;

  logic               self_hit;
  logic               other_hit;
  logic               pair_skip;
  logic signed [COORD_W:0] dx;
  logic signed [COORD_W:0] dy;
  logic               out_free;
  logic               out_load;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                  out_tuser_r;
  logic                  out_tlast_r;

  assign in_slot          = in_tdata[3:0];
  assign in_entry_valid   = in_tdata[4];
  assign in_entry.pos_x   = in_tdata[20:5];
  assign in_entry.pos_y   = in_tdata[36:21];
  assign in_entry.radius  = in_tdata[51:37];
  assign in_shape_kind    = in_tdata[52];
  assign in_entry.member_layer = in_tdata[84:53];
  assign in_entry.collide_mask = in_tdata[116:85];
  assign in_has_handler   = in_tdata[117];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_range  = CMP_W'(in_slot) < CMP_W'(MAX_COLLIDERS);
  assign in_idx    = IDX_W'(in_slot);
  assign j_idx     = j_r[IDX_W-1:0];

  assign ram_wr_en   = in_acc && (in_tuser == CMD_LOAD) && in_range && in_entry_valid;
  assign ram_rd_addr = (state_r == ST_IDLE) ? in_idx : j_idx;
  assign rd_entry    = lccs_entry_t'(ram_rd_data);

  lccs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_COLLIDERS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (in_idx),
    .wr_data (ENTRY_W'(in_entry)),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    unique case (state_r)
      ST_SQ_Y: sq_op = dy_r;
      ST_SQ_R: sq_op = rs_r;
      default: sq_op = dx_r;
    endcase
  end

  lccs_square_unit u_square (
    .clk    (clk),
    .op     (sq_op),
    .prod_r (sq_prod)
  );

  assign self_hit  = |(row_r.collide_mask & rd_entry.member_layer);
  assign other_hit = |(rd_entry.collide_mask & row_r.member_layer);
  assign pair_skip = (!self_hit && !other_hit) || row_other_r || other_shape_r[j_idx];
  assign dx = (COORD_W+1)'(row_r.pos_x) - (COORD_W+1)'(rd_entry.pos_x);
  assign dy = (COORD_W+1)'(row_r.pos_y) - (COORD_W+1)'(rd_entry.pos_y);
  assign out_free = !out_tvalid_r || out_tready;
  assign out_load = out_free &&
                    ((state_r == ST_EMIT_I && self_hit_r && row_handler_r) ||
                     (state_r == ST_EMIT_J && other_hit_r && j_handler_r) ||
                     (state_r == ST_DONE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      valid_r       <= '0;
      other_shape_r <= '0;
      handler_r     <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            slot_r    <= in_slot;
            row_idx_r <= in_idx;
            if (in_tuser == CMD_LOAD) begin
              if (in_range) begin
                valid_r[in_idx]       <= in_entry_valid;
                other_shape_r[in_idx] <= in_entry_valid && in_shape_kind;
                handler_r[in_idx]     <= in_entry_valid && in_has_handler;
              end
            end else if (in_range && valid_r[in_idx]) begin
              state_r <= ST_ROW;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end
        ST_ROW: begin
          row_r         <= rd_entry;
          row_other_r   <= other_shape_r[row_idx_r];
          row_handler_r <= handler_r[row_idx_r];
          j_r           <= CNT_W'(row_idx_r) + CNT_W'(1);
          state_r       <= ST_SEEK;
        end
        ST_SEEK: begin
          if (j_r == CNT_W'(MAX_COLLIDERS)) begin
            state_r <= ST_DONE;
          end else if (valid_r[j_idx]) begin
            state_r <= ST_FETCH;
          end else begin
            j_r <= j_r + CNT_W'(1);
          end
        end
        ST_FETCH: begin
          if (pair_skip) begin
            j_r     <= j_r + CNT_W'(1);
            state_r <= ST_SEEK;
          end else begin
            dx_r        <= dx[COORD_W] ? MAG_W'(-dx) : MAG_W'(dx);
            dy_r        <= dy[COORD_W] ? MAG_W'(-dy) : MAG_W'(dy);
            rs_r        <= MAG_W'(row_r.radius) + MAG_W'(rd_entry.radius);
            self_hit_r  <= self_hit;
            other_hit_r <= other_hit;
            j_handler_r <= handler_r[j_idx];
            state_r     <= ST_SQ_X;
          end
        end
        ST_SQ_X: begin
          state_r <= ST_SQ_Y;
        end
        ST_SQ_Y: begin
          acc_r   <= ACC_W'(sq_prod);
          state_r <= ST_SQ_R;
        end
        ST_SQ_R: begin
          acc_r   <= acc_r + ACC_W'(sq_prod);
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          if (acc_r <= ACC_W'(sq_prod)) begin
            state_r <= ST_EMIT_I;
          end else begin
            j_r     <= j_r + CNT_W'(1);
            state_r <= ST_SEEK;
          end
        end
        ST_EMIT_I: begin
          if (!(self_hit_r && row_handler_r)) begin
            state_r <= ST_EMIT_J;
          end else if (out_free) begin
            out_tdata_r  <= {SLOT_W'(j_idx), SLOT_W'(row_idx_r)};
            out_tuser_r  <= EVT_COLLISION;
            out_tlast_r  <= 1'b0;
            state_r      <= ST_EMIT_J;
          end
        end
        ST_EMIT_J: begin
          if (!(other_hit_r && j_handler_r)) begin
            j_r     <= j_r + CNT_W'(1);
            state_r <= ST_SEEK;
          end else if (out_free) begin
            out_tdata_r  <= {SLOT_W'(row_idx_r), SLOT_W'(j_idx)};
            out_tuser_r  <= EVT_COLLISION;
            out_tlast_r  <= 1'b0;
            j_r          <= j_r + CNT_W'(1);
            state_r      <= ST_SEEK;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_tdata_r  <= {SLOT_W'(0), slot_r};
            out_tuser_r  <= EVT_ROW_DONE;
            out_tlast_r  <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  a_event_pair_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == EVT_COLLISION) |-> (out_tdata[3:0] != out_tdata[7:4]))
    else $error("collision item pairs a slot with itself");

  a_scan_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == CMD_SCAN) |=> !in_tready)
    else $error("input taken while a scan is running");

  a_square_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> ($past(state_r) == ST_SQ_R))
    else $error("compare reached without the radius square");

  a_fetch_valid_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH) |-> valid_r[j_idx])
    else $error("pair test on an empty slot");

endmodule
